// ===== hw/rtl/mandelbrot_membership_test_macros.svh =====
// Assertion macros shared by the Mandelbrot membership test RTL.
`ifndef MANDELBROT_MEMBERSHIP_TEST_MACROS_SVH
`define MANDELBROT_MEMBERSHIP_TEST_MACROS_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define MBT_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked on every clock edge outside reset.
`define MBT_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/mbt_pkg.sv =====
// Package with types, constants and helpers of the Mandelbrot membership test.
`timescale 1ns / 1ps
package mbt_pkg;

   localparam int FRAC_BITS   = 24;
   localparam int MAX_COLUMNS = 1024;
   localparam int MAX_ROWS    = 1024;
   localparam int ESCAPE_SQ   = 100;

   localparam int COORD_W = 10;
   localparam int Z_W     = 32;
   localparam int STEP_W  = 31;
   localparam int ITER_W  = 16;
   localparam int PROD_W  = 2 * Z_W;
   localparam int WIDE_W  = 50;
   localparam int CSR_IDX_W = 3;

   localparam logic [PROD_W-1:0] ESCAPE_LIMIT = PROD_W'(ESCAPE_SQ) << (2 * FRAC_BITS);

   localparam logic signed [WIDE_W-1:0] SAT_HI = {{(WIDE_W-Z_W+1){1'b0}}, {(Z_W-1){1'b1}}};
   localparam logic signed [WIDE_W-1:0] SAT_LO = {{(WIDE_W-Z_W+1){1'b1}}, {(Z_W-1){1'b0}}};

   localparam logic signed [Z_W-1:0] X_ORIGIN_RST = 32'shFE00_0000;
   localparam logic signed [Z_W-1:0] Y_ORIGIN_RST = 32'shFF00_0000;
   localparam logic [STEP_W-1:0]     X_STEP_RST   = 31'd335544;
   localparam logic [STEP_W-1:0]     Y_STEP_RST   = 31'd335544;
   localparam logic [ITER_W-1:0]     ITER_RST     = 16'd1000;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_X_ORIGIN = 3'd0,
      CSR_X_STEP   = 3'd1,
      CSR_Y_ORIGIN = 3'd2,
      CSR_Y_STEP   = 3'd3,
      CSR_MAX_ITER = 3'd4
   } mbt_csr_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL_CR,
      ST_MUL_CI,
      ST_SQ_RE,
      ST_SQ_IM,
      ST_CROSS,
      ST_UPDATE,
      ST_FINISH
   } mbt_state_type;

   typedef struct packed {
      logic signed [Z_W-1:0] x_origin;
      logic [STEP_W-1:0]     x_step;
      logic signed [Z_W-1:0] y_origin;
      logic [STEP_W-1:0]     y_step;
      logic [ITER_W-1:0]     max_iterations;
   } mbt_cfg_type;

   typedef struct packed {
      logic                  hit;
      logic signed [Z_W-1:0] value;
   } mbt_sat_type;

   // Clamps a wide signed sum to the 32-bit range and flags when it had to.
   function automatic mbt_sat_type mbt_clamp(input logic signed [WIDE_W-1:0] v);
      mbt_sat_type r;
      r.hit   = 1'b0;
      r.value = v[Z_W-1:0];
      if (v > SAT_HI) begin
         r.hit   = 1'b1;
         r.value = SAT_HI[Z_W-1:0];
      end else if (v < SAT_LO) begin
         r.hit   = 1'b1;
         r.value = SAT_LO[Z_W-1:0];
      end
      return r;
   endfunction

endpackage

// ===== hw/rtl/mbt_regs.sv =====
// Configuration register file of the Mandelbrot membership test.
`timescale 1ns / 1ps
module mbt_regs (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [mbt_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]                   csr_wdata,
   output mbt_pkg::mbt_cfg_type          cfg
);
   import mbt_pkg::*;

   mbt_cfg_type cfg_ff;
   mbt_cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (mbt_csr_type'(csr_index))
            CSR_X_ORIGIN: cfg_in.x_origin       = csr_wdata;
            CSR_X_STEP:   cfg_in.x_step         = csr_wdata[STEP_W-1:0];
            CSR_Y_ORIGIN: cfg_in.y_origin       = csr_wdata;
            CSR_Y_STEP:   cfg_in.y_step         = csr_wdata[STEP_W-1:0];
            CSR_MAX_ITER: cfg_in.max_iterations = csr_wdata[ITER_W-1:0];
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.x_origin       <= X_ORIGIN_RST;
         cfg_ff.x_step         <= X_STEP_RST;
         cfg_ff.y_origin       <= Y_ORIGIN_RST;
         cfg_ff.y_step         <= Y_STEP_RST;
         cfg_ff.max_iterations <= ITER_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== hw/rtl/mbt_mul.sv =====
// Shared signed 32 by 32 multiplier with a registered product.
`timescale 1ns / 1ps
module mbt_mul (
   input  logic                              clock,
   input  logic signed [mbt_pkg::Z_W-1:0]    mul_a,
   input  logic signed [mbt_pkg::Z_W-1:0]    mul_b,
   output logic signed [mbt_pkg::PROD_W-1:0] prod
);
   import mbt_pkg::*;

   logic signed [PROD_W-1:0] prod_ff;

   assign prod = prod_ff;

   always_ff @(posedge clock) begin
      prod_ff <= PROD_W'(mul_a) * PROD_W'(mul_b);
   end

endmodule

// ===== hw/rtl/mandelbrot_membership_test.sv =====
// Top level of the Mandelbrot membership test: sequencer around one shared multiplier.
`timescale 1ns / 1ps
// The block takes one pixel (column, row), forms c from the origin and step registers,
// and runs up to max_iterations rounds of z = z*z + c in signed Q8.24, answering
// in_set = 1 when |z| stayed below 10 in every round. All products go through one
// registered 32x32 multiplier, so a round runs the steps z.re^2, z.im^2, z.re*z.im and
// update in that order. Forming c takes the states ST_MUL_CR and ST_MUL_CI ahead of
// the rounds, and the last magnitude test with the hand-off to the output register
// follows them; a point whose z saturates ends right after that round's update.
// One point is in work at a time; req_stall is high while a point is in work, and a
// finished result waits in the output register so the next pixel can be taken while
// it is held by rsp_stall.
module mandelbrot_membership_test (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [mbt_pkg::COORD_W-1:0]   req_column,
   input  logic [mbt_pkg::COORD_W-1:0]   req_row,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_in_set,
   output logic [mbt_pkg::COORD_W-1:0]   rsp_column_out,
   output logic [mbt_pkg::COORD_W-1:0]   rsp_row_out,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [mbt_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]                   csr_wdata
);
   import mbt_pkg::*;
   `include "mandelbrot_membership_test_macros.svh"

   mbt_cfg_type cfg;

   mbt_state_type state_ff, state_in;

   logic [COORD_W-1:0]       col_ff, col_in;
   logic [COORD_W-1:0]       row_ff, row_in;
   logic [COORD_W-1:0]       col_c_ff, col_c_in;
   logic [COORD_W-1:0]       row_c_ff, row_c_in;
   logic signed [Z_W-1:0]    c_real_ff, c_real_in;
   logic signed [Z_W-1:0]    c_imag_ff, c_imag_in;
   logic signed [Z_W-1:0]    z_real_ff, z_real_in;
   logic signed [Z_W-1:0]    z_imag_ff, z_imag_in;
   logic signed [PROD_W-1:0] sq_re_ff, sq_re_in;
   logic signed [PROD_W-1:0] sq_im_ff, sq_im_in;
   logic [ITER_W-1:0]        round_count_ff, round_count_in;
   logic                     escaped_ff, escaped_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     rsp_in_set_ff, rsp_in_set_in;
   logic [COORD_W-1:0]       rsp_col_ff, rsp_col_in;
   logic [COORD_W-1:0]       rsp_row_ff, rsp_row_in;

   logic signed [Z_W-1:0]    mul_a;
   logic signed [Z_W-1:0]    mul_b;
   logic signed [PROD_W-1:0] prod;

   mbt_regs u_regs (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   mbt_mul u_mul (
      .clock (clock),
      .mul_a (mul_a),
      .mul_b (mul_b),
      .prod  (prod)
   );

   assign req_stall      = (state_ff != ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_in_set     = rsp_in_set_ff;
   assign rsp_column_out = rsp_col_ff;
   assign rsp_row_out    = rsp_row_ff;

   always_comb begin
      logic signed [PROD_W-1:0] diff;
      logic signed [WIDE_W-1:0] re_wide;
      logic signed [WIDE_W-1:0] im_wide;
      logic signed [WIDE_W-1:0] c_wide;
      logic [PROD_W-1:0]        mag;
      mbt_sat_type              re_sat;
      mbt_sat_type              im_sat;
      mbt_sat_type              c_sat;

      state_in       = state_ff;
      col_in         = col_ff;
      row_in         = row_ff;
      col_c_in       = col_c_ff;
      row_c_in       = row_c_ff;
      c_real_in      = c_real_ff;
      c_imag_in      = c_imag_ff;
      z_real_in      = z_real_ff;
      z_imag_in      = z_imag_ff;
      sq_re_in       = sq_re_ff;
      sq_im_in       = sq_im_ff;
      round_count_in = round_count_ff;
      escaped_in     = escaped_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_in_set_in  = rsp_in_set_ff;
      rsp_col_in     = rsp_col_ff;
      rsp_row_in     = rsp_row_ff;
      mul_a          = '0;
      mul_b          = '0;

      diff    = sq_re_ff - sq_im_ff;
      // The real part takes the floored shift of the square difference; the
      // imaginary part shifts the cross product one less, which doubles it.
      re_wide = WIDE_W'(diff >>> FRAC_BITS) + WIDE_W'(c_real_ff);
      im_wide = WIDE_W'(prod >>> (FRAC_BITS - 1)) + WIDE_W'(c_imag_ff);
      re_sat  = mbt_clamp(re_wide);
      im_sat  = mbt_clamp(im_wide);
      mag     = unsigned'(sq_re_ff) + unsigned'(prod);
      c_wide  = '0;
      c_sat   = '0;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               col_in   = req_column;
               row_in   = req_row;
               col_c_in = req_column;
               row_c_in = req_row;
               if (32'(req_column) > MAX_COLUMNS - 1) begin
                  col_c_in = COORD_W'(MAX_COLUMNS - 1);
               end
               if (32'(req_row) > MAX_ROWS - 1) begin
                  row_c_in = COORD_W'(MAX_ROWS - 1);
               end
               state_in = ST_MUL_CR;
            end
         end
         ST_MUL_CR: begin
            mul_a    = signed'(Z_W'(col_c_ff));
            mul_b    = signed'({1'b0, cfg.x_step});
            state_in = ST_MUL_CI;
         end
         ST_MUL_CI: begin
            mul_a          = signed'(Z_W'(row_c_ff));
            mul_b          = signed'({1'b0, cfg.y_step});
            c_wide         = WIDE_W'(prod) + WIDE_W'(cfg.x_origin);
            c_sat          = mbt_clamp(c_wide);
            c_real_in      = c_sat.value;
            z_real_in      = '0;
            z_imag_in      = '0;
            round_count_in = '0;
            escaped_in     = 1'b0;
            state_in       = ST_SQ_RE;
         end
         ST_SQ_RE: begin
            // On the first round this picks up row * y_step for c.imag.
            if (round_count_ff == '0) begin
               c_wide    = WIDE_W'(prod) + WIDE_W'(cfg.y_origin);
               c_sat     = mbt_clamp(c_wide);
               c_imag_in = c_sat.value;
            end
            mul_a    = z_real_ff;
            mul_b    = z_real_ff;
            state_in = ST_SQ_IM;
         end
         ST_SQ_IM: begin
            sq_re_in = prod;
            mul_a    = z_imag_ff;
            mul_b    = z_imag_ff;
            state_in = ST_CROSS;
         end
         ST_CROSS: begin
            // The squares of the current z serve both the escape test of the
            // last round and the next round's update.
            sq_im_in = prod;
            if (mag >= ESCAPE_LIMIT) begin
               escaped_in = 1'b1;
               state_in   = ST_FINISH;
            end else if (round_count_ff >= cfg.max_iterations) begin
               state_in = ST_FINISH;
            end else begin
               mul_a    = z_real_ff;
               mul_b    = z_imag_ff;
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            z_real_in      = re_sat.value;
            z_imag_in      = im_sat.value;
            round_count_in = round_count_ff + ITER_W'(1);
            if (re_sat.hit || im_sat.hit) begin
               escaped_in = 1'b1;
               state_in   = ST_FINISH;
            end else begin
               state_in = ST_SQ_RE;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_in_set_in = !escaped_ff;
               rsp_col_in    = col_ff;
               rsp_row_in    = row_ff;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         rsp_valid_ff   <= 1'b0;
         round_count_ff <= '0;
         escaped_ff     <= 1'b0;
      end else begin
         state_ff       <= state_in;
         rsp_valid_ff   <= rsp_valid_in;
         round_count_ff <= round_count_in;
         escaped_ff     <= escaped_in;
      end
   end

   always_ff @(posedge clock) begin
      col_ff        <= col_in;
      row_ff        <= row_in;
      col_c_ff      <= col_c_in;
      row_c_ff      <= row_c_in;
      c_real_ff     <= c_real_in;
      c_imag_ff     <= c_imag_in;
      z_real_ff     <= z_real_in;
      z_imag_ff     <= z_imag_in;
      sq_re_ff      <= sq_re_in;
      sq_im_ff      <= sq_im_in;
      rsp_in_set_ff <= rsp_in_set_in;
      rsp_col_ff    <= rsp_col_in;
      rsp_row_ff    <= rsp_row_in;
   end

   `MBT_ASSERT_NOW(a_round_bound, state_ff != ST_IDLE && state_ff != ST_MUL_CR && state_ff != ST_MUL_CI, round_count_ff <= cfg.max_iterations, "round count ran past max_iterations")
   `MBT_ASSERT_NOW(a_in_set_full, state_ff == ST_FINISH && !escaped_ff, round_count_ff >= cfg.max_iterations, "point judged inside before all rounds ran")
   `MBT_ASSERT_NEXT(a_hold_result, state_ff == ST_FINISH && rsp_valid_ff && rsp_stall, state_ff == ST_FINISH && rsp_valid_ff, "finished point overwrote a waiting result")

endmodule

// ===== tb/tb_mandelbrot_membership_test.sv =====
// Self-checking testbench of the Mandelbrot membership test block.
`timescale 1ns / 1ps
module tb_mandelbrot_membership_test;
   import mbt_pkg::*;

   localparam int CLOCK_PERIOD   = 20;
   localparam int RESET_CYCLES   = 8;
   localparam int RANDOM_PIXELS  = 450;
   // The slowest point runs 65535 rounds with nothing accepted meanwhile.
   localparam int WATCHDOG_LIMIT = 1_100_000;
   localparam int TAIL_LIMIT     = 2000;
   localparam int MAX_REPORTS    = 100;

   localparam longint WORD_MAX = 64'sd2147483647;
   localparam longint WORD_MIN = -64'sd2147483648;

   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_FIRST = CSR_IDX_W'(CSR_MAX_ITER + 1);

   typedef struct packed {
      logic               in_set;
      logic [COORD_W-1:0] column;
      logic [COORD_W-1:0] row;
   } pixel_answer_type;

   class membership_tracker_type;
      mbt_cfg_type      cfg;
      pixel_answer_type pending_answers[$];
      int unsigned      errors;

      function new();
         cfg.x_origin       = X_ORIGIN_RST;
         cfg.x_step         = X_STEP_RST;
         cfg.y_origin       = Y_ORIGIN_RST;
         cfg.y_step         = Y_STEP_RST;
         cfg.max_iterations = ITER_RST;
         errors             = 0;
      endfunction

      function void apply_register(input logic [CSR_IDX_W-1:0] reg_index,
                                   input logic [31:0] data);
         case (reg_index)
            CSR_X_ORIGIN: begin
               cfg.x_origin = data;
            end
            CSR_X_STEP: begin
               cfg.x_step = data[STEP_W-1:0];
            end
            CSR_Y_ORIGIN: begin
               cfg.y_origin = data;
            end
            CSR_Y_STEP: begin
               cfg.y_step = data[STEP_W-1:0];
            end
            CSR_MAX_ITER: begin
               cfg.max_iterations = data[ITER_W-1:0];
            end
            default: begin
            end
         endcase
      endfunction

      static function longint clamp_word(input longint v, inout bit hit);
         if (v > WORD_MAX) begin
            hit = 1'b1;
            return WORD_MAX;
         end
         if (v < WORD_MIN) begin
            hit = 1'b1;
            return WORD_MIN;
         end
         return v;
      endfunction

      function bit predict_in_set(input logic [COORD_W-1:0] column,
                                  input logic [COORD_W-1:0] row);
         longint      col_idx, row_idx, x_org, y_org, x_inc, y_inc;
         longint      c_re, c_im, z_re, z_im, next_re, next_im;
         logic [63:0] mag_sq;
         int unsigned rounds;
         bit          escaped, hit;
         col_idx = column;
         row_idx = row;
         if (col_idx > MAX_COLUMNS - 1) begin
            col_idx = MAX_COLUMNS - 1;
         end
         if (row_idx > MAX_ROWS - 1) begin
            row_idx = MAX_ROWS - 1;
         end
         x_org = $signed(cfg.x_origin);
         y_org = $signed(cfg.y_origin);
         x_inc = cfg.x_step;
         y_inc = cfg.y_step;
         // A clamped c is not an escape; the rounds go on with it.
         hit  = 1'b0;
         c_re = clamp_word(x_org + col_idx * x_inc, hit);
         c_im = clamp_word(y_org + row_idx * y_inc, hit);
         z_re    = 0;
         z_im    = 0;
         escaped = 1'b0;
         rounds  = 0;
         while (rounds < cfg.max_iterations && !escaped) begin
            next_re = ((z_re * z_re - z_im * z_im) >>> FRAC_BITS) + c_re;
            next_im = ((2 * z_re * z_im) >>> FRAC_BITS) + c_im;
            hit     = 1'b0;
            z_re    = clamp_word(next_re, hit);
            z_im    = clamp_word(next_im, hit);
            rounds++;
            // The sum of squares may wrap as signed; as 64 unsigned bits it is exact.
            mag_sq = z_re * z_re + z_im * z_im;
            if (hit || mag_sq >= ESCAPE_LIMIT) begin
               escaped = 1'b1;
            end
         end
         return !escaped;
      endfunction

      function void note_pixel(input logic [COORD_W-1:0] column,
                               input logic [COORD_W-1:0] row);
         pixel_answer_type answer;
         answer.in_set = predict_in_set(column, row);
         answer.column = column;
         answer.row    = row;
         pending_answers.push_back(answer);
      endfunction

      function int pending();
         return pending_answers.size();
      endfunction

      task report_mismatch(input string what);
         if (errors < MAX_REPORTS) begin
            $display("[%0t] mismatch: %s", $realtime, what);
         end
         errors++;
      endtask

      task check_result(input logic in_set, input logic [COORD_W-1:0] column,
                        input logic [COORD_W-1:0] row);
         pixel_answer_type want;
         if (pending_answers.size() == 0) begin
            report_mismatch($sformatf("result beat for (%0d,%0d) with none pending",
                                      column, row));
            return;
         end
         want = pending_answers.pop_front();
         if (column !== want.column) begin
            report_mismatch($sformatf("column_out %0d, expected %0d", column, want.column));
         end
         if (row !== want.row) begin
            report_mismatch($sformatf("row_out %0d, expected %0d", row, want.row));
         end
         if (in_set !== want.in_set) begin
            report_mismatch($sformatf("in_set %0b for (%0d,%0d), expected %0b",
                                      in_set, want.column, want.row, want.in_set));
         end
      endtask
   endclass

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic [COORD_W-1:0]   req_column = '0;
   logic [COORD_W-1:0]   req_row = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic                 rsp_in_set;
   logic [COORD_W-1:0]   rsp_column_out;
   logic [COORD_W-1:0]   rsp_row_out;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [31:0]          csr_wdata = '0;

   int unsigned sender_idle_pct   = 0;
   int unsigned receiver_idle_pct = 0;
   int unsigned quiet_cycles      = 0;

   membership_tracker_type tracker = new();

   mandelbrot_membership_test i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_column     (req_column),
      .req_row        (req_row),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_in_set     (rsp_in_set),
      .rsp_column_out (rsp_column_out),
      .rsp_row_out    (rsp_row_out),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(99) < receiver_idle_pct);
      end
   end

   // Beats are taken from the values that stood before this edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            tracker.note_pixel(req_column, req_row);
         end
         if (rsp_valid && !rsp_stall) begin
            tracker.check_result(rsp_in_set, rsp_column_out, rsp_row_out);
         end
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
             (csr_valid && csr_ready)) begin
            quiet_cycles <= 0;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("TEST FAILED");
            $finish;
         end
      end
   end

   task automatic send_pixel(input logic [COORD_W-1:0] column,
                             input logic [COORD_W-1:0] row);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_column <= column;
      req_row    <= row;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic release_request();
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic wait_for_results();
      release_request();
      while (tracker.pending() != 0) begin
         @(posedge clock);
      end
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] reg_index,
                                 input logic [31:0] data);
      csr_valid <= 1'b1;
      csr_index <= reg_index;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      tracker.apply_register(reg_index, data);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // A view near the set mostly; otherwise raw random bits, but max_iterations from 1 to 63.
   task automatic load_random_view(input bit noisy);
      int          origin;
      logic [31:0] raw;
      if (noisy) begin
         write_register(CSR_X_ORIGIN, $urandom());
         write_register(CSR_X_STEP, $urandom());
         write_register(CSR_Y_ORIGIN, $urandom());
         write_register(CSR_Y_STEP, $urandom());
         raw = $urandom();
         write_register(CSR_MAX_ITER, (raw & 32'hFFFF_0000) | $urandom_range(1, 63));
         write_register(CSR_UNUSED_FIRST + CSR_IDX_W'($urandom_range(2)), $urandom());
      end else begin
         origin = -41943040 + int'($urandom_range(0, 16777216));
         write_register(CSR_X_ORIGIN, origin);
         write_register(CSR_X_STEP, $urandom_range(8192, 65536) | ($urandom_range(1) << 31));
         origin = -25165824 + int'($urandom_range(0, 16777216));
         write_register(CSR_Y_ORIGIN, origin);
         write_register(CSR_Y_STEP, $urandom_range(8192, 65536) | ($urandom_range(1) << 31));
         if ($urandom_range(5) == 0) begin
            write_register(CSR_MAX_ITER, $urandom_range(65, 400));
         end else begin
            write_register(CSR_MAX_ITER, $urandom_range(1, 64));
         end
      end
   endtask

   initial begin
      int unsigned random_sent;
      int unsigned batch;
      int unsigned tail;
      sender_idle_pct   = 15;
      receiver_idle_pct = 79;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Registers as they come out of reset: near corner, origin area, far corner.
      send_pixel(10'd0, 10'd0);
      send_pixel(10'd100, 10'd50);
      send_pixel(10'd1023, 10'd1023);
      wait_for_results();

      // No rounds at all means every point counts as inside; unused indexes are ignored.
      write_register(CSR_MAX_ITER, 32'd0);
      write_register(CSR_UNUSED_FIRST, 32'hFFFF_FFFF);
      write_register(CSR_UNUSED_FIRST + CSR_IDX_W'(1), 32'h5555_5555);
      write_register(CSR_UNUSED_FIRST + CSR_IDX_W'(2), 32'hAAAA_AAAA);
      send_pixel(10'd0, 10'd0);
      send_pixel(10'd1023, 10'd1023);
      wait_for_results();

      // Origins at both extremes and steps at their largest, so c reaches both ends and clamps at the top.
      write_register(CSR_X_ORIGIN, 32'h7FFF_FFFF);
      write_register(CSR_X_STEP, 32'hFFFF_FFFF);
      write_register(CSR_Y_ORIGIN, 32'h8000_0000);
      write_register(CSR_Y_STEP, 32'hFFFF_FFFF);
      write_register(CSR_MAX_ITER, 32'd1);
      send_pixel(10'd0, 10'd0);
      send_pixel(10'd1023, 10'd0);
      send_pixel(10'd0, 10'd1023);
      send_pixel(10'd1023, 10'd1023);
      send_pixel(10'd512, 10'd512);
      wait_for_results();

      // A magnitude of exactly ten escapes; just below it does not.
      write_register(CSR_X_STEP, 32'd0);
      write_register(CSR_Y_ORIGIN, 32'd0);
      write_register(CSR_Y_STEP, 32'd0);
      write_register(CSR_X_ORIGIN, 32'h0A00_0000);
      send_pixel(10'd7, 10'd9);
      wait_for_results();
      write_register(CSR_X_ORIGIN, 32'h09FF_FFFF);
      send_pixel(10'd7, 10'd9);
      wait_for_results();
      write_register(CSR_X_ORIGIN, 32'hF600_0000);
      send_pixel(10'd7, 10'd9);
      wait_for_results();

      // c = -2 settles at z = 2 and stays inside.
      write_register(CSR_X_ORIGIN, 32'hFE00_0000);
      write_register(CSR_MAX_ITER, 32'd50);
      send_pixel(10'd300, 10'd300);
      wait_for_results();

      // c = 0 never escapes, so this point runs the full round count.
      write_register(CSR_X_ORIGIN, 32'd0);
      write_register(CSR_MAX_ITER, 32'hFFFF_FFFF);
      send_pixel(10'd1, 10'd2);
      wait_for_results();

      random_sent = 0;
      while (random_sent < RANDOM_PIXELS) begin
         wait_for_results();
         load_random_view($urandom_range(9) == 0);
         batch = $urandom_range(8, 30);
         repeat (batch) begin
            if (random_sent >= 2 * RANDOM_PIXELS / 3) begin
               sender_idle_pct   = 0;
               receiver_idle_pct = 0;
            end else if (random_sent >= RANDOM_PIXELS / 3) begin
               sender_idle_pct   = 79;
               receiver_idle_pct = 15;
            end
            // Now and then hold off until the block has answered everything.
            if ($urandom_range(29) == 0) begin
               wait_for_results();
            end
            send_pixel(COORD_W'($urandom_range(MAX_COLUMNS - 1)),
                       COORD_W'($urandom_range(MAX_ROWS - 1)));
            random_sent++;
         end
      end

      wait_for_results();
      tail = 4 * tracker.cfg.max_iterations + 16;
      if (tail > TAIL_LIMIT) begin
         tail = TAIL_LIMIT;
      end
      repeat (tail) @(posedge clock);
      if (tracker.errors == 0 && tracker.pending() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
